// ===== rtl/core/idq_pkg.sv =====
// idq_pkg: shared constants, operation and status codes, word types
// for the indexed deque. No dependencies.

package idq_pkg;

    // Storage geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic signed [31:0] data_t;

    typedef struct packed {
        logic [2:0] operation;
        data_t      value;
        logic [3:0] position;
    } idq_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
        data_t      front_value;
        logic       front_valid;
        data_t      back_value;
        logic       back_valid;
    } idq_rsp_t;

endpackage

// ===== rtl/core/idq_ifs.sv =====
// idq_ifs: valid/ready channel interfaces for request and response words.
// Depends on idq_pkg.

interface idq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    idq_pkg::data_t     value;
    logic [3:0]         position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface idq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         count;
    idq_pkg::data_t     front_value;
    logic               front_valid;
    idq_pkg::data_t     back_value;
    logic               back_valid;

    modport source (output valid, output status, output count, output front_value,
                    output front_valid, output back_value, output back_valid,
                    input ready);
    modport sink   (input valid, input status, input count, input front_value,
                    input front_valid, input back_value, input back_valid,
                    output ready);
endinterface

// ===== rtl/core/idq_store.sv =====
// idq_store: entry register array with per-slot shift muxes, entry count,
// and the combinational evaluation of an operation. Depends on idq_pkg.

module idq_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  idq_pkg::idq_req_t item,
    output idq_pkg::idq_rsp_t result
);
    import idq_pkg::*;

    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    data_t            entries_reg [CAPACITY];
    data_t            entries_next [CAPACITY];
    data_t            view [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] back_pos;
    logic [1:0]       status;
    logic             modify;
    logic             is_full;
    logic             is_empty;
    logic             pos_ok;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_ok   = (CMP_W'(item.position) < CMP_W'(count_reg));

    // Operation decode: status, new count, whether the slots move
    always_comb
    begin
        status     = ST_DONE;
        count_next = count_reg;
        modify     = 1'b0;
        case (item.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    modify     = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status = ST_IGNORED;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    modify     = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                    status = ST_IGNORED;
                else
                    count_next = count_reg - 1'b1;
            end
            OP_REMOVE:
            begin
                if (!pos_ok)
                begin
                    status = ST_IGNORED;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    modify     = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_IGNORED;
            end
        endcase
    end

    // Per-slot shift muxes; each slot looks only at its neighbors
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (item.operation)
                OP_PUSH_FRONT:
                    entries_next[i] = (i == 0) ? item.value
                                               : entries_reg[(i == 0) ? 0 : i - 1];
                OP_PUSH_BACK:
                    entries_next[i] = (CNT_W'(i) == count_reg) ? item.value
                                                               : entries_reg[i];
                OP_POP_FRONT:
                    entries_next[i] = entries_reg[(i == CAPACITY - 1) ? i : i + 1];
                OP_REMOVE:
                    entries_next[i] = (CMP_W'(i) >= CMP_W'(item.position))
                                      ? entries_reg[(i == CAPACITY - 1) ? i : i + 1]
                                      : entries_reg[i];
                default:
                    entries_next[i] = entries_reg[i];
            endcase
            view[i] = modify ? entries_next[i] : entries_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && modify)
        begin
            for (int i = 0; i < CAPACITY; i++)
                entries_reg[i] <= entries_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (commit)
            count_reg <= count_next;
    end

    assign back_pos = count_next - 1'b1;

    always_comb
    begin
        result.status      = status;
        result.count       = 5'(count_next);
        result.front_valid = (count_next != '0);
        result.back_valid  = (count_next != '0);
        result.front_value = (count_next != '0) ? view[0] : '0;
        result.back_value  = (count_next != '0) ? view[back_pos[IDX_W-1:0]] : '0;
    end

endmodule

// ===== rtl/core/indexed_deque.sv =====
// indexed_deque: bounded double-ended queue with indexed remove.
// An accepted word waits in the input stage; its response is registered in the output stage.
// Throughput: one word per cycle while rsp.ready stays high; the store updates all slots together.
// Reset (rst_n, async, active low): queue empty, both stages empty.
// Entry contents are not reset; only slots below the count are ever read.
// Depends on idq_pkg, idq_ifs, idq_store.

module indexed_deque (
    input  logic       clk,
    input  logic       rst_n,
    idq_req_if.sink    req,
    idq_rsp_if.source  rsp
);
    import idq_pkg::*;

    // Input stage: holds the word being evaluated against the store
    logic     s1_valid_reg;
    idq_req_t s1_item_reg;

    // Output stage: finished response waiting for the consumer
    logic     out_valid_reg;
    idq_rsp_t out_item_reg;

    idq_rsp_t result;
    logic     advance;
    logic     commit;

    // The output stage can take a word if it is empty or being drained
    assign advance = !out_valid_reg || rsp.ready;
    // Operation takes effect in the store when it moves to the output stage
    assign commit  = s1_valid_reg && advance;
    // Input stage refills whenever its word moves on
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg.operation <= req.operation;
            s1_item_reg.value     <= req.value;
            s1_item_reg.position  <= req.position;
        end
    end

    idq_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_item_reg <= result;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_item_reg.status;
    assign rsp.count       = out_item_reg.count;
    assign rsp.front_value = out_item_reg.front_value;
    assign rsp.front_valid = out_item_reg.front_valid;
    assign rsp.back_value  = out_item_reg.back_value;
    assign rsp.back_valid  = out_item_reg.back_valid;

endmodule

// ===== rtl/core/idq_checker.sv =====
// idq_checker: port-level assertions for indexed_deque, bound to the top.
// Depends on idq_pkg.

module idq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [4:0] rsp_count,
    input logic       rsp_front_valid,
    input logic       rsp_back_valid
);
    import idq_pkg::*;

    // Both valid flags track a nonzero count
    a_valid_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_front_valid == (rsp_count != 5'd0))
                      && (rsp_back_valid == rsp_front_valid))
        else $error("front/back valid flags disagree with count");

    // Count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_count) <= CAPACITY))
        else $error("count above capacity");

    // A full report only comes with a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == ST_FULL) |-> (32'(rsp_count) == CAPACITY))
        else $error("full status with room left");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_IGNORED
                       || rsp_status == ST_FULL))
        else $error("undefined status code");

    // A stalled response word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response word withdrawn while stalled");

endmodule

bind indexed_deque idq_checker u_idq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_count       (rsp.count),
    .rsp_front_valid (rsp.front_valid),
    .rsp_back_valid  (rsp.back_valid)
);

// ===== tb/indexed_deque_checker.sv =====
`timescale 1ns / 1ps
// indexed_deque_checker: watches the request and response channels of the deque,
// predicts each response word from its own copy of the queue and compares field by field.
// Depends on idq_pkg and idq_ifs.

module indexed_deque_checker (
    input  logic clk,
    input  logic rst_n,
    idq_req_if   req,
    idq_rsp_if   rsp,
    output int   failures,
    output int   pending,
    output int   checked
);
    import idq_pkg::*;

    data_t    slots [CAPACITY];
    int       fill = 0;
    idq_rsp_t expected_rsps [$];
    idq_rsp_t want;
    int       mismatch_cnt = 0;
    int       checked_cnt = 0;

    // Close the gap left by slot p; p is below fill.
    function automatic void drop_slot(input int p);
        for (int i = p; i + 1 < fill; i++)
            slots[i] = slots[i + 1];
        fill--;
    endfunction

    function automatic idq_rsp_t predict_rsp(input logic [2:0] op, input data_t val,
                                             input logic [3:0] pos);
        idq_rsp_t r;
        r.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = fill; i > 0; i--)
                        slots[i] = slots[i - 1];
                    slots[0] = val;
                    fill++;
                end
            end
            OP_PUSH_BACK:
            begin
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    slots[fill] = val;
                    fill++;
                end
            end
            OP_POP_FRONT:
            begin
                if (fill == 0)
                    r.status = ST_IGNORED;
                else
                    drop_slot(0);
            end
            OP_POP_BACK:
            begin
                if (fill == 0)
                    r.status = ST_IGNORED;
                else
                    fill--;
            end
            OP_REMOVE:
            begin
                if (int'(pos) >= fill)
                    r.status = ST_IGNORED;
                else
                    drop_slot(int'(pos));
            end
            OP_CLEAR:
                fill = 0;
            default:
                r.status = ST_IGNORED;
        endcase
        r.count       = 5'(fill);
        r.front_valid = (fill > 0);
        r.back_valid  = (fill > 0);
        r.front_value = (fill > 0) ? slots[0] : '0;
        r.back_value  = (fill > 0) ? slots[fill - 1] : '0;
        return r;
    endfunction

    task automatic report(input string msg);
        mismatch_cnt++;
        $display("[%0t] MISMATCH word %0d: %s", $time, checked_cnt, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            expected_rsps.delete();
            pending  <= 0;
            failures <= mismatch_cnt;
            checked  <= checked_cnt;
        end
        else
        begin
            // Request pushed before the response pops; a response never belongs to
            // a request accepted at the same edge.
            if (req.valid && req.ready)
                expected_rsps.push_back(predict_rsp(req.operation, req.value, req.position));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                    report("response word with nothing outstanding");
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("status %0d, expected %0d", rsp.status, want.status));
                    if (rsp.count !== want.count)
                        report($sformatf("count %0d, expected %0d", rsp.count, want.count));
                    if (rsp.front_value !== want.front_value)
                        report($sformatf("front_value %0h, expected %0h",
                                         rsp.front_value, want.front_value));
                    if (rsp.front_valid !== want.front_valid)
                        report($sformatf("front_valid %0b, expected %0b",
                                         rsp.front_valid, want.front_valid));
                    if (rsp.back_value !== want.back_value)
                        report($sformatf("back_value %0h, expected %0h",
                                         rsp.back_value, want.back_value));
                    if (rsp.back_valid !== want.back_valid)
                        report($sformatf("back_valid %0b, expected %0b",
                                         rsp.back_valid, want.back_valid));
                    checked_cnt++;
                end
            end
            pending  <= expected_rsps.size();
            failures <= mismatch_cnt;
            checked  <= checked_cnt;
        end
    end

endmodule

// ===== tb/indexed_deque_tb.sv =====
`timescale 1ns / 1ps
// indexed_deque_tb: top of the deque testbench; clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on idq_pkg, idq_ifs,
// indexed_deque and indexed_deque_checker.

module indexed_deque_tb;

    import idq_pkg::*;

    // Codes 6 and 7 are not operations; the block must ignore them.
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    localparam int RANDOM_WORDS = 1300;

    logic clk;
    logic rst_n;

    idq_req_if req ();
    idq_rsp_if rsp ();

    int chk_failures;
    int chk_pending;
    int chk_checked;

    int words_sent = 0;
    int op_hist [8];

    // Quiet flags turn off idling on one side for a stretch of words.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    indexed_deque i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    indexed_deque_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .failures (chk_failures),
        .pending  (chk_pending),
        .checked  (chk_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run of about 1350 words.
    initial
    begin
        #5ms;
        $display("timeout with %0d response words outstanding", chk_pending);
        $display("TEST FAILED");
        $finish;
    end

    // Mostly full-range random, with the corner values mixed in often enough
    // to hit them many times.
    function automatic data_t pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return data_t'($urandom);
        endcase
    endfunction

    // One request word: random gap with valid low (payload churns so the block
    // must ignore it), then hold valid until the block takes the word.
    // Called right after the previous acceptance edge, so valid gets one
    // assignment per step: low for a gap, or straight back high.
    task automatic send_word(input logic [2:0] op, input data_t val, input logic [3:0] pos);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            req.valid <= 1'b0;
            req.value <= data_t'($urandom);
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value     <= val;
        req.position  <= pos;
        do
            @(posedge clk);
        while (!req.ready);
        words_sent++;
        op_hist[op]++;
    endtask

    // Stop sending until every outstanding response word has come back.
    // The wait before the first check lets the checker's count catch the last acceptance.
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // Response side: after each accepted word, draw a random stall with ready low.
    // Quiet stretches keep ready high throughout.
    initial
    begin
        int stall;
        stall     = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                stall = rx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        int         done;
        int         phase_left;
        int         roll;
        int         k;
        bit         filling;
        logic [2:0] op;
        logic [3:0] pos;
        data_t      val;

        done       = 0;
        phase_left = 0;
        filling    = 1'b0;

        req.valid     = 1'b0;
        req.operation = OP_PUSH_FRONT;
        req.value     = '0;
        req.position  = '0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Empty queue first: both pops are ignored, clear is done.
        send_word(OP_POP_FRONT, 32'd0, 4'd0);
        send_word(OP_POP_BACK, 32'd0, 4'd0);
        send_word(OP_CLEAR, 32'd0, 4'd0);

        // Fill to capacity from both ends, corner values first.
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (i)
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = 32'h0000_0000;
                3:       val = 32'hFFFF_FFFF;
                default: val = data_t'($urandom);
            endcase
            send_word((i % 2 == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, val, 4'd0);
        end

        // Full queue drops pushes at both ends.
        send_word(OP_PUSH_FRONT, 32'h1234_5678, 4'd0);
        send_word(OP_PUSH_BACK, 32'h8765_4321, 4'd0);

        // Remove the last slot while full, then the same position is out of range.
        send_word(OP_REMOVE, 32'd0, 4'd15);
        send_word(OP_REMOVE, 32'd0, 4'd15);

        send_word(OP_RESERVED_6, 32'hDEAD_BEEF, 4'd3);
        send_word(OP_RESERVED_7, 32'hCAFE_F00D, 4'd0);

        // Hold off until the block has answered everything so far.
        wait_drained();

        // Random part in phases: filling phases lean on pushes and reach the full
        // queue, draining phases lean on pops and removes and empty it again.
        while (done < RANDOM_WORDS)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(10, 60);
                tx_quiet   = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end

            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = OP_CLEAR;
            else if (roll < 4)
                op = (roll == 2) ? OP_RESERVED_6 : OP_RESERVED_7;
            else if (roll < (filling ? 75 : 30))
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_POP_FRONT;
                    1:       op = OP_POP_BACK;
                    default: op = OP_REMOVE;
                endcase
            end

            // Half the positions near the front, where most entries live.
            pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));

            send_word(op, pick_value(), pos);
            done++;
            phase_left--;
        end

        // Drain with a bound, then let the pipeline settle.
        req.valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < 1000 && chk_pending != 0; k++)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run: %0d request words (push %0d/%0d, pop %0d/%0d, remove %0d, clear %0d,",
                 words_sent, op_hist[OP_PUSH_FRONT], op_hist[OP_PUSH_BACK],
                 op_hist[OP_POP_FRONT], op_hist[OP_POP_BACK], op_hist[OP_REMOVE],
                 op_hist[OP_CLEAR]);
        $display("     reserved %0d), %0d responses compared, %0d mismatches",
                 op_hist[OP_RESERVED_6] + op_hist[OP_RESERVED_7], chk_checked, chk_failures);
        if (chk_pending != 0)
            $display("%0d response words never arrived", chk_pending);

        if (chk_failures == 0 && chk_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/idq_pkg.sv
rtl/core/idq_ifs.sv
rtl/core/idq_store.sv
rtl/core/indexed_deque.sv
rtl/core/idq_checker.sv
tb/indexed_deque_checker.sv
tb/indexed_deque_tb.sv
